@@ src/slhh_pkg.sv @@
// ----------------------------------------------------------------------------
// slhh_pkg
// Shared types and constants of the secure link header handler.
// ----------------------------------------------------------------------------
package slhh_pkg;

    localparam int MaxNodes = 16;
    localparam int IdxW     = $clog2(MaxNodes);
    localparam int CntW     = $clog2(MaxNodes + 1);

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_DEL    = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] ST_UNKNOWN   = 2'd0;
    localparam logic [1:0] ST_CONNECTED = 2'd1;
    localparam logic [1:0] ST_SEQERR    = 2'd2;
    localparam logic [1:0] ST_SETSEQ    = 2'd3;

    localparam logic [1:0] VERDICT_REJECT  = 2'd0;
    localparam logic [1:0] VERDICT_DATA    = 2'd1;
    localparam logic [1:0] VERDICT_CONTROL = 2'd2;
    localparam logic [1:0] VERDICT_UNKNOWN = 2'd3;

    localparam logic [2:0] REG_DEV_ADDR = 3'd0;
    localparam logic [2:0] REG_VERSION  = 3'd1;
    localparam logic [2:0] REG_DATA     = 3'd2;
    localparam logic [2:0] REG_ACK      = 3'd3;
    localparam logic [2:0] REG_SEQERR   = 3'd4;
    localparam logic [2:0] REG_SETSEQ   = 3'd5;

    localparam logic [15:0] LEN_MASK = 16'hFFF0;
    localparam logic [15:0] LEN_PAD  = 16'd15;

    // Table entry
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] seq;
        logic [1:0]  status;
    } t_node;

    // Configuration registers
    typedef struct packed {
        logic [31:0] dev_addr;
        logic [7:0]  version;
        logic [7:0]  data_code;
        logic [7:0]  ack_code;
        logic [7:0]  seqerr_code;
        logic [7:0]  setseq_code;
    } t_cfg;

endpackage

@@ src/secure_link_header_handler_top.sv @@
// ----------------------------------------------------------------------------
// secure_link_header_handler_top
// Receive-side header checks and node table of a sequenced link.
// ----------------------------------------------------------------------------
// A single address comparator walks the node table one entry a cycle to
// find the source, and a delete then shifts the entries above the hit down
// one a cycle through the same table port. Add and clear finish after the
// search. Input stall is high from acceptance until the result has been
// taken by the output side.
module secure_link_header_handler_top import slhh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_src_address,
    input  logic [31:0] i_dst_address,
    input  logic [7:0]  i_version,
    input  logic [7:0]  i_flags,
    input  logic [15:0] i_seq_id,
    input  logic [15:0] i_reserved_word,
    input  logic [15:0] i_data_length,
    input  logic [6:0]  i_encrypted_available,
    input  logic        i_awaiting_ack,
    input  logic [15:0] i_initial_seq,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_resp_valid,
    output logic [7:0]  o_resp_flags,
    output logic [31:0] o_resp_dst,
    output logic [15:0] o_resp_seq,
    output logic [15:0] o_resp_reserved,
    output logic [1:0]  o_verdict,
    output logic        o_ack_received,
    output logic        o_op_ok,
    output logic [4:0]  o_node_total,
    output logic [31:0] o_seq_set_total
);
    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_SHIFT, S_EXEC, S_OUT} t_state;

    t_cfg   cfg;
    t_state r_state;
    t_node  r_tab [MaxNodes];
    logic [CntW-1:0] r_count;
    logic [31:0]     r_setcnt;
    logic [CntW-1:0] r_ptr;
    logic            r_found;
    logic [IdxW-1:0] r_hit;
    t_node           r_node;

    // Latched request
    logic [1:0]  r_kind;
    logic [31:0] r_src, r_dst;
    logic [7:0]  r_ver, r_flg;
    logic [15:0] r_seq, r_rsv, r_len, r_init;
    logic [6:0]  r_avail;
    logic        r_wait;

    // Result registers
    logic        r_rvalid, r_acked, r_ok;
    logic [7:0]  r_rflags;
    logic [31:0] r_rdst;
    logic [15:0] r_rseq, r_rres;
    logic [1:0]  r_verdict;

    logic [15:0] len_pad;
    logic        hdr_ok;

    slhh_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign len_pad = (r_len + LEN_PAD) & LEN_MASK;
    assign hdr_ok  = (r_dst == cfg.dev_addr) && (r_ver == cfg.version) &&
                     (len_pad == {9'd0, r_avail}) && r_found;

    // Sequencer: search, shift, execute, present
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_setcnt <= '0;
            r_ptr    <= '0;
            r_found  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_kind;
                        r_src   <= i_src_address;
                        r_dst   <= i_dst_address;
                        r_ver   <= i_version;
                        r_flg   <= i_flags;
                        r_seq   <= i_seq_id;
                        r_rsv   <= i_reserved_word;
                        r_len   <= i_data_length;
                        r_avail <= i_encrypted_available;
                        r_wait  <= i_awaiting_ack;
                        r_init  <= i_initial_seq;
                        r_ptr   <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // compare one entry a cycle
                    if (r_ptr >= r_count) begin
                        r_state <= S_EXEC;
                    end else if (r_tab[r_ptr[IdxW-1:0]].addr == r_src) begin
                        r_found <= 1'b1;
                        r_hit   <= r_ptr[IdxW-1:0];
                        r_node  <= r_tab[r_ptr[IdxW-1:0]];
                        r_ptr   <= r_ptr + 1'b1;
                        r_state <= (r_kind == KIND_DEL) ? S_SHIFT : S_EXEC;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_SHIFT: begin
                    // move entry above down by one
                    if (r_ptr >= r_count) begin
                        r_state <= S_EXEC;
                    end else begin
                        r_tab[r_ptr[IdxW-1:0] - 1'b1] <= r_tab[r_ptr[IdxW-1:0]];
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_EXEC: begin
                    r_rvalid  <= 1'b0;
                    r_rflags  <= '0;
                    r_rdst    <= '0;
                    r_rseq    <= '0;
                    r_rres    <= '0;
                    r_verdict <= VERDICT_REJECT;
                    r_acked   <= 1'b0;
                    r_ok      <= 1'b0;
                    r_state   <= S_OUT;
                    case (r_kind)
                        KIND_ADD: begin
                            if (r_count < CntW'(MaxNodes) && !r_found) begin
                                r_tab[r_count[IdxW-1:0]] <= '{r_src, r_init, ST_UNKNOWN};
                                r_count <= r_count + 1'b1;
                                r_ok    <= 1'b1;
                            end
                        end
                        KIND_DEL: begin
                            if (r_found) begin
                                r_count <= r_count - 1'b1;
                                r_ok    <= 1'b1;
                            end
                        end
                        KIND_CLEAR: begin
                            r_count <= '0;
                            r_ok    <= 1'b1;
                        end
                        default: begin
                            if (hdr_ok) begin
                                if (r_flg == cfg.data_code) begin
                                    r_rvalid <= 1'b1;
                                    r_rdst   <= r_src;
                                    if (r_seq == r_node.seq) begin
                                        r_tab[r_hit].status <= ST_CONNECTED;
                                        r_tab[r_hit].seq    <= r_node.seq + 16'd1;
                                        r_rflags  <= cfg.ack_code;
                                        r_rseq    <= r_node.seq;
                                        r_verdict <= VERDICT_DATA;
                                    end else begin
                                        r_tab[r_hit].status <= ST_SEQERR;
                                        r_rflags  <= cfg.seqerr_code;
                                        r_rseq    <= r_seq;
                                        r_rres    <= r_node.seq;
                                        r_verdict <= VERDICT_CONTROL;
                                    end
                                end else if (r_flg == cfg.ack_code) begin
                                    r_verdict <= VERDICT_CONTROL;
                                    if (r_wait && r_seq == r_node.seq) begin
                                        r_tab[r_hit].status <= ST_CONNECTED;
                                        r_tab[r_hit].seq    <= r_node.seq + 16'd1;
                                        r_acked <= 1'b1;
                                    end
                                end else if (r_flg == cfg.seqerr_code) begin
                                    r_verdict <= VERDICT_CONTROL;
                                    if (r_wait && r_seq == r_node.seq) begin
                                        r_tab[r_hit].status <= ST_SETSEQ;
                                        r_rvalid <= 1'b1;
                                        r_rdst   <= r_src;
                                        r_rflags <= cfg.setseq_code;
                                        r_rseq   <= r_rsv;
                                        r_rres   <= r_rsv ^ r_node.seq;
                                    end
                                end else if (r_flg == cfg.setseq_code) begin
                                    r_verdict <= VERDICT_CONTROL;
                                    if (r_node.status == ST_SEQERR && r_seq == r_node.seq) begin
                                        r_rvalid <= 1'b1;
                                        r_rdst   <= r_src;
                                        r_rflags <= cfg.setseq_code;
                                        r_rseq   <= r_rsv ^ r_node.seq;
                                        r_rres   <= r_rsv;
                                        r_tab[r_hit].status <= ST_CONNECTED;
                                        r_tab[r_hit].seq    <= r_rsv;
                                        r_setcnt <= r_setcnt + 32'd1;
                                    end else if (r_node.status == ST_SETSEQ &&
                                                 r_seq == r_node.seq) begin
                                        r_tab[r_hit].status <= ST_CONNECTED;
                                        r_tab[r_hit].seq    <= r_rsv;
                                        r_setcnt <= r_setcnt + 32'd1;
                                    end else begin
                                        r_tab[r_hit].status <= ST_UNKNOWN;
                                    end
                                end else begin
                                    r_verdict <= VERDICT_UNKNOWN;
                                end
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_resp_valid    = r_rvalid;
    assign o_resp_flags    = r_rflags;
    assign o_resp_dst      = r_rdst;
    assign o_resp_seq      = r_rseq;
    assign o_resp_reserved = r_rres;
    assign o_verdict       = r_verdict;
    assign o_ack_received  = r_acked;
    assign o_op_ok         = r_ok;
    assign o_node_total    = 5'(r_count);
    assign o_seq_set_total = r_setcnt;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxNodes)) else $error("node count overflow");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= CntW'(MaxNodes + 1)) else $error("walk pointer overrun");
    a_ok_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_op_ok |-> r_kind != KIND_HEADER) else $error("op_ok on header");
    a_resp_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_resp_valid |-> r_kind == KIND_HEADER && r_found)
        else $error("response without known source");
endmodule

@@ src/slhh_cfg.sv @@
// ----------------------------------------------------------------------------
// slhh_cfg
// Configuration register file with write port.
// ----------------------------------------------------------------------------
module slhh_cfg import slhh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);
    t_cfg r_cfg;

    // Store register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr    <= '0;
            r_cfg.version     <= 8'd1;
            r_cfg.data_code   <= 8'd0;
            r_cfg.ack_code    <= 8'd1;
            r_cfg.seqerr_code <= 8'd2;
            r_cfg.setseq_code <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEV_ADDR: r_cfg.dev_addr    <= i_cfg_data;
                REG_VERSION:  r_cfg.version     <= i_cfg_data[7:0];
                REG_DATA:     r_cfg.data_code   <= i_cfg_data[7:0];
                REG_ACK:      r_cfg.ack_code    <= i_cfg_data[7:0];
                REG_SEQERR:   r_cfg.seqerr_code <= i_cfg_data[7:0];
                REG_SETSEQ:   r_cfg.setseq_code <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

@@ tb/slhh_link_checker.sv @@
// ----------------------------------------------------------------------------
// slhh_link_checker
// Watches the request and result channels of the header handler, keeps its
// own copy of the node table and registers, and compares every result.
// ----------------------------------------------------------------------------
module slhh_link_checker import slhh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_src_address,
    input  logic [31:0] i_dst_address,
    input  logic [7:0]  i_version,
    input  logic [7:0]  i_flags,
    input  logic [15:0] i_seq_id,
    input  logic [15:0] i_reserved_word,
    input  logic [15:0] i_data_length,
    input  logic [6:0]  i_encrypted_available,
    input  logic        i_awaiting_ack,
    input  logic [15:0] i_initial_seq,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic        i_resp_valid,
    input  logic [7:0]  i_resp_flags,
    input  logic [31:0] i_resp_dst,
    input  logic [15:0] i_resp_seq,
    input  logic [15:0] i_resp_reserved,
    input  logic [1:0]  i_verdict,
    input  logic        i_ack_received,
    input  logic        i_op_ok,
    input  logic [4:0]  i_node_total,
    input  logic [31:0] i_seq_set_total,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        resp_valid;
        logic [7:0]  resp_flags;
        logic [31:0] resp_dst;
        logic [15:0] resp_seq;
        logic [15:0] resp_reserved;
        logic [1:0]  verdict;
        logic        ack_received;
        logic        op_ok;
        logic [4:0]  node_total;
        logic [31:0] seq_set_total;
    } t_outcome;

    t_cfg     cfg;
    t_node    table_q [MaxNodes];
    int       node_cnt;
    logic [31:0] resync_cnt;
    t_outcome outcome_q [$];

    function automatic int lookup_node(logic [31:0] addr);
        for (int k = 0; k < node_cnt; k++) begin
            if (table_q[IdxW'(k)].addr == addr) return k;
        end
        return -1;
    endfunction

    // Work out the result of one request and update the table copy
    function automatic t_outcome handle_request();
        t_outcome r;
        int       n;
        logic [IdxW-1:0] hit;
        logic [15:0] nseq;
        logic [1:0]  nst;
        logic [15:0] padded;
        r = '0;
        n = lookup_node(i_src_address);
        hit = IdxW'(n);
        case (i_kind)
            KIND_ADD: begin
                if (node_cnt < MaxNodes && n < 0) begin
                    table_q[IdxW'(node_cnt)] = '{i_src_address, i_initial_seq, ST_UNKNOWN};
                    node_cnt++;
                    r.op_ok = 1'b1;
                end
            end
            KIND_DEL: begin
                if (n >= 0) begin
                    for (int k = n + 1; k < node_cnt; k++)
                        table_q[IdxW'(k - 1)] = table_q[IdxW'(k)];
                    node_cnt--;
                    r.op_ok = 1'b1;
                end
            end
            KIND_CLEAR: begin
                node_cnt = 0;
                r.op_ok = 1'b1;
            end
            default: begin
                padded = (i_data_length + LEN_PAD) & LEN_MASK;
                if (i_dst_address == cfg.dev_addr && i_version == cfg.version &&
                    padded == 16'(i_encrypted_available) && n >= 0) begin
                    nseq = table_q[hit].seq;
                    nst  = table_q[hit].status;
                    r.verdict = VERDICT_CONTROL;
                    if (i_flags == cfg.data_code) begin
                        r.resp_valid = 1'b1;
                        if (i_seq_id == nseq) begin
                            table_q[hit].status = ST_CONNECTED;
                            table_q[hit].seq = nseq + 16'd1;
                            r.resp_flags = cfg.ack_code;
                            r.resp_seq = nseq;
                            r.verdict = VERDICT_DATA;
                        end else begin
                            table_q[hit].status = ST_SEQERR;
                            r.resp_flags = cfg.seqerr_code;
                            r.resp_seq = i_seq_id;
                            r.resp_reserved = nseq;
                        end
                    end else if (i_flags == cfg.ack_code) begin
                        if (i_awaiting_ack && i_seq_id == nseq) begin
                            table_q[hit].status = ST_CONNECTED;
                            table_q[hit].seq = nseq + 16'd1;
                            r.ack_received = 1'b1;
                        end
                    end else if (i_flags == cfg.seqerr_code) begin
                        if (i_awaiting_ack && i_seq_id == nseq) begin
                            table_q[hit].status = ST_SETSEQ;
                            r.resp_valid = 1'b1;
                            r.resp_flags = cfg.setseq_code;
                            r.resp_seq = i_reserved_word;
                            r.resp_reserved = i_reserved_word ^ nseq;
                        end
                    end else if (i_flags == cfg.setseq_code) begin
                        if (nst == ST_SEQERR && i_seq_id == nseq) begin
                            r.resp_valid = 1'b1;
                            r.resp_flags = cfg.setseq_code;
                            r.resp_seq = i_reserved_word ^ nseq;
                            r.resp_reserved = i_reserved_word;
                            table_q[hit].status = ST_CONNECTED;
                            table_q[hit].seq = i_reserved_word;
                            resync_cnt++;
                        end else if (nst == ST_SETSEQ && i_seq_id == nseq) begin
                            table_q[hit].status = ST_CONNECTED;
                            table_q[hit].seq = i_reserved_word;
                            resync_cnt++;
                        end else begin
                            table_q[hit].status = ST_UNKNOWN;
                        end
                    end else begin
                        r.verdict = VERDICT_UNKNOWN;
                    end
                    if (r.resp_valid) r.resp_dst = i_src_address;
                end
            end
        endcase
        r.node_total = 5'(node_cnt);
        r.seq_set_total = resync_cnt;
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    assign o_pending = outcome_q.size();

    // Track registers, predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_outcome w;
        if (!i_rst_n) begin
            cfg <= '{32'd0, 8'd1, 8'd0, 8'd1, 8'd2, 8'd3};
            node_cnt = 0;
            resync_cnt = '0;
            outcome_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEV_ADDR: cfg.dev_addr    <= i_cfg_data;
                    REG_VERSION:  cfg.version     <= i_cfg_data[7:0];
                    REG_DATA:     cfg.data_code   <= i_cfg_data[7:0];
                    REG_ACK:      cfg.ack_code    <= i_cfg_data[7:0];
                    REG_SEQERR:   cfg.seqerr_code <= i_cfg_data[7:0];
                    REG_SETSEQ:   cfg.setseq_code <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall) outcome_q.push_back(handle_request());
            if (i_res_valid && !i_res_stall) begin
                if (outcome_q.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fail_count++;
                end else begin
                    w = outcome_q.pop_front();
                    compare_field("resp_valid", w.resp_valid, i_resp_valid);
                    compare_field("resp_flags", w.resp_flags, i_resp_flags);
                    compare_field("resp_dst", w.resp_dst, i_resp_dst);
                    compare_field("resp_seq", w.resp_seq, i_resp_seq);
                    compare_field("resp_reserved", w.resp_reserved, i_resp_reserved);
                    compare_field("verdict", w.verdict, i_verdict);
                    compare_field("ack_received", w.ack_received, i_ack_received);
                    compare_field("op_ok", w.op_ok, i_op_ok);
                    compare_field("node_total", w.node_total, i_node_total);
                    compare_field("seq_set_total", w.seq_set_total, i_seq_set_total);
                end
            end
        end
    end

endmodule

@@ tb/tb_secure_link_header_handler_top.sv @@
// ----------------------------------------------------------------------------
// tb_secure_link_header_handler_top
// Drives table and header requests with random gaps and stalls through
// several register settings; a checker beside the block predicts results.
// ----------------------------------------------------------------------------
module tb_secure_link_header_handler_top import slhh_pkg::*;;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_valid, o_stall;
    logic [1:0]  i_kind;
    logic [31:0] i_src_address, i_dst_address;
    logic [7:0]  i_version, i_flags;
    logic [15:0] i_seq_id, i_reserved_word, i_data_length;
    logic [6:0]  i_encrypted_available;
    logic        i_awaiting_ack;
    logic [15:0] i_initial_seq;
    logic        o_valid, i_stall;
    logic        o_resp_valid;
    logic [7:0]  o_resp_flags;
    logic [31:0] o_resp_dst;
    logic [15:0] o_resp_seq, o_resp_reserved;
    logic [1:0]  o_verdict;
    logic        o_ack_received, o_op_ok;
    logic [4:0]  o_node_total;
    logic [31:0] o_seq_set_total;
    int          fail_count, pending;

    int          send_idle_pct, recv_stall_pct;
    logic [31:0] own_addr;
    logic [7:0]  own_ver;
    logic [7:0]  codes [4];
    logic [31:0] peers [8];
    logic [15:0] peer_seq [8];

    secure_link_header_handler_top u_top (.*);

    slhh_link_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_req_valid(i_valid), .i_req_stall(o_stall),
        .i_kind, .i_src_address, .i_dst_address, .i_version, .i_flags,
        .i_seq_id, .i_reserved_word, .i_data_length, .i_encrypted_available,
        .i_awaiting_ack, .i_initial_seq,
        .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_resp_valid(o_resp_valid), .i_resp_flags(o_resp_flags),
        .i_resp_dst(o_resp_dst), .i_resp_seq(o_resp_seq),
        .i_resp_reserved(o_resp_reserved), .i_verdict(o_verdict),
        .i_ack_received(o_ack_received), .i_op_ok(o_op_ok),
        .i_node_total(o_node_total), .i_seq_set_total(o_seq_set_total),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Random receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_DEV_ADDR) own_addr = val;
        if (idx == REG_VERSION) own_ver = val[7:0];
        if (idx >= REG_DATA) codes[2'(idx - REG_DATA)] = val[7:0];
    endtask

    // Drop valid, hold until every result is in, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (MaxNodes + 8) @(posedge i_clk);
    endtask

    // Present one request and hold it until taken
    task automatic send(logic [1:0] kind, logic [31:0] src, logic [31:0] dst,
                        logic [7:0] ver, logic [7:0] flg, logic [15:0] seq,
                        logic [15:0] rsv, logic [15:0] len, logic [6:0] avail,
                        logic wait_ack, logic [15:0] init);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind; i_src_address <= src; i_dst_address <= dst;
        i_version <= ver; i_flags <= flg; i_seq_id <= seq;
        i_reserved_word <= rsv; i_data_length <= len;
        i_encrypted_available <= avail; i_awaiting_ack <= wait_ack;
        i_initial_seq <= init;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Header from a random peer, mostly well formed
    task automatic send_header();
        logic [2:0]  p;
        logic [15:0] len;
        logic [15:0] seq;
        p   = 3'($urandom_range(7));
        len = 16'($urandom_range(112));
        seq = ($urandom_range(3) != 0) ? peer_seq[p] : 16'($urandom);
        if ($urandom_range(9) == 0) begin
            send(KIND_HEADER, $urandom, $urandom, 8'($urandom), 8'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom), 7'($urandom),
                 1'($urandom), 16'($urandom));
        end else begin
            send(KIND_HEADER, peers[p],
                 ($urandom_range(19) == 0) ? ~own_addr : own_addr,
                 ($urandom_range(19) == 0) ? ~own_ver : own_ver,
                 ($urandom_range(9) == 0) ? 8'($urandom) : codes[2'($urandom_range(3))],
                 seq, 16'($urandom), len,
                 ($urandom_range(19) == 0) ? 7'($urandom) : 7'((len + 15) & 16'hFFF0),
                 $urandom_range(4) != 0, 16'($urandom));
            if (seq == peer_seq[p]) peer_seq[p] = peer_seq[p] + 16'd1;
        end
    endtask

    task automatic random_phase(int count, int s_pct, int r_pct);
        logic [2:0] p;
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(19))
                0, 1: begin
                    p = 3'($urandom_range(7));
                    peer_seq[p] = 16'($urandom);
                    send(KIND_ADD, peers[p], $urandom, 8'($urandom), 8'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom), 7'($urandom),
                         1'($urandom), peer_seq[p]);
                end
                2: send(KIND_DEL, peers[3'($urandom_range(7))], $urandom,
                        8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 7'($urandom), 1'($urandom), 16'($urandom));
                3: if ($urandom_range(3) == 0)
                    send(KIND_CLEAR, $urandom, $urandom, 8'($urandom), 8'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom), 7'($urandom),
                         1'($urandom), 16'($urandom));
                default: send_header();
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_kind = '0; i_src_address = '0; i_dst_address = '0;
        i_version = '0; i_flags = '0; i_seq_id = '0; i_reserved_word = '0;
        i_data_length = '0; i_encrypted_available = '0; i_awaiting_ack = 1'b0;
        i_initial_seq = '0; i_stall = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0;
        own_addr = 32'd0; own_ver = 8'd1;
        codes = '{8'd0, 8'd1, 8'd2, 8'd3};
        for (int k = 0; k < 8; k++) begin
            peers[3'(k)] = $urandom; peer_seq[3'(k)] = '0;
        end
        peers[0] = 32'hFFFF_FFFF; peers[1] = 32'h0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill past capacity, duplicate, delete absent, clear
        send(KIND_ADD, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF);
        send(KIND_ADD, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0);
        for (int k = 1; k <= MaxNodes; k++)
            send(KIND_ADD, k, 0, 0, 0, 0, 0, 0, 0, 0, 16'(k));
        send(KIND_DEL, 32'd1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send(KIND_DEL, 32'd1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Data wrapping sequence, wrong sequence, setseq after seqerr
        send(KIND_HEADER, 32'hFFFF_FFFF, 0, 8'd1, 8'd0, 16'hFFFF, 0, 16'd0, 7'd0, 0, 0);
        send(KIND_HEADER, 32'hFFFF_FFFF, 0, 8'd1, 8'd0, 16'h1234, 0, 16'd1, 7'd16, 0, 0);
        send(KIND_HEADER, 32'hFFFF_FFFF, 0, 8'd1, 8'd3, 16'h0000, 16'hFFFF, 16'd112,
             7'd112, 0, 0);
        send(KIND_HEADER, 32'hFFFF_FFFF, 0, 8'd1, 8'd2, 16'hFFFF, 16'h00AA, 16'd16,
             7'd16, 1, 0);
        send(KIND_HEADER, 32'hFFFF_FFFF, 0, 8'd1, 8'd3, 16'hFFFF, 16'h0001, 16'd0,
             7'd0, 0, 0);
        send(KIND_HEADER, 32'hFFFF_FFFF, 0, 8'd1, 8'd1, 16'h0001, 0, 16'hFFFF, 7'd0, 1, 0);
        send(KIND_HEADER, 32'hFFFF_FFFF, 0, 8'd1, 8'd3, 16'h7777, 0, 16'd0, 7'd0, 0, 0);
        send(KIND_HEADER, 32'hFFFF_FFFF, 0, 8'd1, 8'hFF, 0, 0, 0, 7'd0, 0, 0);
        send(KIND_HEADER, 32'hFFFF_FFFF, 0, 8'd2, 8'd0, 0, 0, 0, 7'd127, 0, 0);
        send(KIND_HEADER, 32'h5555_5555, 0, 8'd1, 8'd0, 0, 0, 0, 0, 0, 0);
        send(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // Extreme settings with all flag codes equal
        write_reg(REG_DEV_ADDR, 32'hFFFF_FFFF);
        write_reg(REG_VERSION, 32'hFF);
        for (int r = REG_DATA; r <= REG_SETSEQ; r++) write_reg(3'(r), 32'hFF);
        for (int k = 0; k < 8; k++) begin
            peer_seq[3'(k)] = 16'($urandom);
            send(KIND_ADD, peers[3'(k)], 0, 0, 0, 0, 0, 0, 0, 0, peer_seq[3'(k)]);
        end
        random_phase(60, 6, 84);
        drain();

        // Random distinct-ish codes
        write_reg(REG_DEV_ADDR, $urandom);
        write_reg(REG_VERSION, 32'h00);
        for (int r = REG_DATA; r <= REG_SETSEQ; r++) write_reg(3'(r), $urandom);
        random_phase(140, 84, 6);
        // Hold off until the block has answered everything
        drain();
        write_reg(REG_DEV_ADDR, 32'h0);
        write_reg(REG_VERSION, 32'h1);
        for (int r = REG_DATA; r <= REG_SETSEQ; r++) write_reg(3'(r), r - REG_DATA);
        random_phase(180, 0, 0);
        drain();

        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
src/slhh_pkg.sv
src/slhh_cfg.sv
src/secure_link_header_handler_top.sv
tb/slhh_link_checker.sv
tb/tb_secure_link_header_handler_top.sv
